@@ rtl/core/gre_rco_pkg.sv @@
// Shared types and constants for the GRE receive check and reorder block.
package gre_rco_pkg;

    localparam int QDEPTH   = 16;
    localparam int QIDX_W   = $clog2(QDEPTH);
    localparam int OCC_W    = QIDX_W + 1;
    localparam int HANDLE_W = 8;

    localparam logic [15:0] BITS_MASK = 16'hEF7F;
    localparam logic [15:0] BITS_WANT = 16'h2001;
    localparam int          SEQ_BIT   = 12;
    localparam int          ACK_BIT   = 7;
    localparam logic [15:0] GRE_TYPE  = 16'h880B;
    localparam logic [7:0]  ADDR_BYTE = 8'hFF;
    localparam logic [7:0]  CTRL_BYTE = 8'h03;

    localparam logic [1:0] REG_CALL_ID = 2'd0;
    localparam logic [1:0] REG_THRESH  = 2'd1;
    localparam logic [1:0] REG_HZ      = 2'd2;

    typedef enum logic [1:0] {
        KIND_DELIVER = 2'd0,
        KIND_DROP    = 2'd1,
        KIND_PURGE   = 2'd2
    } kind_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_INSERT,
        ST_DRAIN,
        ST_PURGE,
        ST_FLUSH
    } state_t;

    typedef struct packed {
        logic drop;
        logic seqd;
        logic strip;
        logic prep;
    } chk_t;

    typedef struct packed {
        kind_t               kind;
        logic [HANDLE_W-1:0] handle;
        logic                strip;
        logic                prep;
    } res_t;

endpackage

@@ rtl/core/gre_rco_if.sv @@
// Valid/ready channel interfaces for packet descriptors and results.
interface gre_rco_item_if;
    logic        valid;
    logic        ready;
    logic        op;
    logic [7:0]  handle;
    logic [15:0] total_length;
    logic [15:0] gre_flags;
    logic [15:0] gre_protocol;
    logic [15:0] payload_length;
    logic [15:0] call_id;
    logic [31:0] sequence_req;
    logic [7:0]  byte0;
    logic [7:0]  byte1;
    logic [7:0]  byte2;

    modport source (output valid, op, handle, total_length, gre_flags, gre_protocol,
                    payload_length, call_id, sequence_req, byte0, byte1, byte2,
                    input ready);
    modport sink   (input valid, op, handle, total_length, gre_flags, gre_protocol,
                    payload_length, call_id, sequence_req, byte0, byte1, byte2,
                    output ready);
endinterface

interface gre_rco_result_if;
    logic       valid;
    logic       ready;
    logic [1:0] kind;
    logic [7:0] out_handle;
    logic       strip_addr_ctrl;
    logic       prepend_zero;
    logic       last;

    modport source (output valid, kind, out_handle, strip_addr_ctrl, prepend_zero, last,
                    input ready);
    modport sink   (input valid, kind, out_handle, strip_addr_ctrl, prepend_zero, last,
                    output ready);
endinterface

@@ rtl/core/gre_receive_check_and_reorder.sv @@
// Top level: GRE receive check, sorted reorder queue and release sequencer.
// Flow: a drop or unsequenced delivery passes the pending and then the output register; a purge
//   gives one result per cycle while the output accepts. A sequenced packet scans the queue
//   one entry a cycle through the shared serial compare, then is inserted and ready heads released.
// Handshake: not ready outside the idle state, so a new item waits until the last one is through.
// Reset: queue empty, expected sequence, tick count and timer cleared; no clearing pass.
module gre_receive_check_and_reorder (
    input  logic                clk,
    input  logic                rst_n,
    gre_rco_item_if.sink        item,
    gre_rco_result_if.source    result,
    input  logic                cfg_we,
    input  logic [1:0]          cfg_index,
    input  logic [15:0]         cfg_data
);
    import gre_rco_pkg::*;

    logic [31:0]         q_seq    [QDEPTH];
    logic [31:0]         q_stamp  [QDEPTH];
    logic [HANDLE_W-1:0] q_handle [QDEPTH];
    logic                q_strip  [QDEPTH];
    logic                q_prep   [QDEPTH];

    logic [15:0] call_id_reg;
    logic [4:0]  thresh_reg;
    logic [9:0]  hz_reg;

    state_t      state_reg, state_next;
    logic [OCC_W-1:0] occ_reg, occ_next;
    logic [OCC_W-1:0] idx_reg, idx_next;
    logic [OCC_W-1:0] pos_reg, pos_next;
    logic [31:0] stamp_reg, stamp_next;
    logic [31:0] exp_reg, exp_next;
    logic [31:0] now_reg, now_next;
    logic        armed_reg, armed_next;
    logic [31:0] dl_reg, dl_next;

    logic [31:0]         it_seq_reg;
    logic [HANDLE_W-1:0] it_handle_reg;
    logic                it_strip_reg;
    logic                it_prep_reg;

    logic  pend_v_reg, pend_v_next;
    res_t  pend_reg, pend_next;
    logic  out_v_reg, out_v_next;
    res_t  out_reg, out_next;
    logic  out_last_reg, out_last_next;

    chk_t        chk;
    logic        accept;
    logic        out_free;
    logic        can_gen;
    logic        gen;
    res_t        gen_res;
    logic        flush_emit;
    logic        ins_en;
    logic        pop_en;
    logic [31:0] now_inc;
    logic [31:0] tick_diff;
    logic        tick_due;
    logic [31:0] seq_rd;
    logic [31:0] stamp_rd;
    logic [31:0] scan_diff;
    logic [4:0]  thr;
    logic [9:0]  age;
    logic        release_head;

    gre_rco_chk u_chk (
        .total_length      (item.total_length),
        .gre_flags         (item.gre_flags),
        .gre_protocol      (item.gre_protocol),
        .payload_length    (item.payload_length),
        .call_id           (item.call_id),
        .sequence_req      (item.sequence_req),
        .byte0             (item.byte0),
        .byte1             (item.byte1),
        .byte2             (item.byte2),
        .local_call_id     (call_id_reg),
        .expected_sequence (exp_reg),
        .chk               (chk)
    );

    assign item.ready             = (state_reg == ST_IDLE);
    assign accept                 = item.valid && item.ready;
    assign result.valid           = out_v_reg;
    assign result.kind            = out_reg.kind;
    assign result.out_handle      = out_reg.handle;
    assign result.strip_addr_ctrl = out_reg.strip;
    assign result.prepend_zero    = out_reg.prep;
    assign result.last            = out_last_reg;

    assign out_free  = !out_v_reg || result.ready;
    assign can_gen   = !pend_v_reg || out_free;
    assign now_inc   = now_reg + 32'd1;
    assign tick_diff = now_inc - dl_reg;
    assign tick_due  = armed_reg && !tick_diff[31];
    assign seq_rd    = q_seq[idx_reg[QIDX_W-1:0]];
    assign stamp_rd  = q_stamp[idx_reg[QIDX_W-1:0]];
    assign scan_diff = it_seq_reg - seq_rd;
    assign thr       = (thresh_reg > 5'(QDEPTH)) ? 5'(QDEPTH) : thresh_reg;
    assign age       = (hz_reg > 10'd5) ? hz_reg - 10'd5 : 10'd0;
    assign release_head = (occ_reg != '0)
                       && ((occ_reg >= thr) || ((now_reg - q_stamp[0]) >= {22'd0, age})
                           || (q_seq[0] == exp_reg));

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    if (item.op)
                        state_next = tick_due ? ST_DRAIN : ST_IDLE;
                    else if (chk.drop)
                        state_next = ST_FLUSH;
                    else if (chk.seqd)
                        state_next = ST_SCAN;
                    else
                        state_next = ST_PURGE;
                end
            end
            ST_SCAN:
            begin
                if (idx_reg == occ_reg || scan_diff[31])
                    state_next = ST_INSERT;
                else if (scan_diff == 32'd0)
                    state_next = ST_FLUSH;
            end
            ST_INSERT:
                state_next = (occ_reg == OCC_W'(QDEPTH)) ? ST_FLUSH : ST_DRAIN;
            ST_DRAIN:
                if (!release_head)
                    state_next = ST_FLUSH;
            ST_PURGE:
                if (idx_reg >= occ_reg && can_gen)
                    state_next = ST_FLUSH;
            ST_FLUSH:
                if (!pend_v_reg || out_free)
                    state_next = ST_IDLE;
            default:
                state_next = ST_IDLE;
        endcase
    end

    // datapath and outputs
    always_comb
    begin
        occ_next   = occ_reg;
        idx_next   = idx_reg;
        pos_next   = pos_reg;
        stamp_next = stamp_reg;
        exp_next   = exp_reg;
        now_next   = now_reg;
        armed_next = armed_reg;
        dl_next    = dl_reg;
        gen        = 1'b0;
        gen_res    = '{kind: KIND_DROP, handle: it_handle_reg, strip: 1'b0, prep: 1'b0};
        flush_emit = 1'b0;
        ins_en     = 1'b0;
        pop_en     = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    idx_next = '0;
                    if (item.op)
                    begin
                        now_next = now_inc;
                        if (tick_due)
                            armed_next = 1'b0;
                    end
                    else if (chk.drop)
                    begin
                        gen     = 1'b1;
                        gen_res = '{kind: KIND_DROP, handle: item.handle, strip: 1'b0,
                                    prep: 1'b0};
                    end
                    else if (chk.seqd)
                        armed_next = 1'b0;
                end
            end
            ST_SCAN:
            begin
                if (idx_reg == occ_reg)
                begin
                    pos_next   = occ_reg;
                    stamp_next = now_reg;
                end
                else if (scan_diff == 32'd0)
                    gen = 1'b1;
                else if (scan_diff[31])
                begin
                    pos_next   = idx_reg;
                    stamp_next = stamp_rd;
                end
                else
                    idx_next = idx_reg + OCC_W'(1);
            end
            ST_INSERT:
            begin
                if (occ_reg == OCC_W'(QDEPTH))
                    gen = 1'b1;
                else
                begin
                    ins_en   = 1'b1;
                    occ_next = occ_reg + OCC_W'(1);
                end
            end
            ST_DRAIN:
            begin
                if (release_head)
                begin
                    if (can_gen)
                    begin
                        gen      = 1'b1;
                        gen_res  = '{kind: KIND_DELIVER, handle: q_handle[0],
                                     strip: q_strip[0], prep: q_prep[0]};
                        exp_next = q_seq[0] + 32'd1;
                        pop_en   = 1'b1;
                        occ_next = occ_reg - OCC_W'(1);
                    end
                end
                else if (occ_reg != '0 && !armed_reg)
                begin
                    armed_next = 1'b1;
                    dl_next    = now_reg + {22'd0, hz_reg};
                end
            end
            ST_PURGE:
            begin
                if (can_gen)
                begin
                    gen = 1'b1;
                    if (idx_reg < occ_reg)
                    begin
                        gen_res  = '{kind: KIND_PURGE, handle: q_handle[idx_reg[QIDX_W-1:0]],
                                     strip: 1'b0, prep: 1'b0};
                        idx_next = idx_reg + OCC_W'(1);
                    end
                    else
                    begin
                        gen_res  = '{kind: KIND_DELIVER, handle: it_handle_reg,
                                     strip: it_strip_reg, prep: it_prep_reg};
                        occ_next = '0;
                    end
                end
            end
            ST_FLUSH:
                flush_emit = pend_v_reg && out_free;
            default:
            begin
            end
        endcase
    end

    // pending result and output register
    always_comb
    begin
        pend_v_next   = pend_v_reg;
        pend_next     = pend_reg;
        out_v_next    = out_v_reg;
        out_next      = out_reg;
        out_last_next = out_last_reg;
        if (out_v_reg && result.ready)
            out_v_next = 1'b0;
        if (gen)
        begin
            if (pend_v_reg)
            begin
                out_v_next    = 1'b1;
                out_next      = pend_reg;
                out_last_next = 1'b0;
            end
            pend_v_next = 1'b1;
            pend_next   = gen_res;
        end
        if (flush_emit)
        begin
            out_v_next    = 1'b1;
            out_next      = pend_reg;
            out_last_next = 1'b1;
            pend_v_next   = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            occ_reg      <= '0;
            idx_reg      <= '0;
            pos_reg      <= '0;
            exp_reg      <= '0;
            now_reg      <= '0;
            armed_reg    <= 1'b0;
            dl_reg       <= '0;
            pend_v_reg   <= 1'b0;
            out_v_reg    <= 1'b0;
            call_id_reg  <= 16'd0;
            thresh_reg   <= 5'd16;
            hz_reg       <= 10'd100;
        end
        else
        begin
            state_reg  <= state_next;
            occ_reg    <= occ_next;
            idx_reg    <= idx_next;
            pos_reg    <= pos_next;
            exp_reg    <= exp_next;
            now_reg    <= now_next;
            armed_reg  <= armed_next;
            dl_reg     <= dl_next;
            pend_v_reg <= pend_v_next;
            out_v_reg  <= out_v_next;
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_CALL_ID: call_id_reg <= cfg_data;
                    REG_THRESH:  thresh_reg  <= cfg_data[4:0];
                    REG_HZ:      hz_reg      <= cfg_data[9:0];
                    default:
                    begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        stamp_reg    <= stamp_next;
        pend_reg     <= pend_next;
        out_reg      <= out_next;
        out_last_reg <= out_last_next;
        if (accept)
        begin
            it_seq_reg    <= item.sequence_req;
            it_handle_reg <= item.handle;
            it_strip_reg  <= chk.strip;
            it_prep_reg   <= chk.prep;
        end
    end

    // queue storage: sorted insert shifts up, head release shifts down
    always_ff @(posedge clk)
    begin
        for (int i = 0; i < QDEPTH; i++)
        begin
            if (ins_en)
            begin
                if (OCC_W'(i) == pos_reg)
                begin
                    q_seq[i]    <= it_seq_reg;
                    q_stamp[i]  <= stamp_reg;
                    q_handle[i] <= it_handle_reg;
                    q_strip[i]  <= it_strip_reg;
                    q_prep[i]   <= it_prep_reg;
                end
                else if (i > 0 && OCC_W'(i) > pos_reg)
                begin
                    q_seq[i]    <= q_seq[(i + QDEPTH - 1) % QDEPTH];
                    q_stamp[i]  <= q_stamp[(i + QDEPTH - 1) % QDEPTH];
                    q_handle[i] <= q_handle[(i + QDEPTH - 1) % QDEPTH];
                    q_strip[i]  <= q_strip[(i + QDEPTH - 1) % QDEPTH];
                    q_prep[i]   <= q_prep[(i + QDEPTH - 1) % QDEPTH];
                end
            end
            else if (pop_en && i < QDEPTH - 1)
            begin
                q_seq[i]    <= q_seq[(i + 1) % QDEPTH];
                q_stamp[i]  <= q_stamp[(i + 1) % QDEPTH];
                q_handle[i] <= q_handle[(i + 1) % QDEPTH];
                q_strip[i]  <= q_strip[(i + 1) % QDEPTH];
                q_prep[i]   <= q_prep[(i + 1) % QDEPTH];
            end
        end
    end

`ifndef SYNTHESIS
    a_occ_range: assert property (@(posedge clk) disable iff (!rst_n)
        occ_reg <= OCC_W'(QDEPTH))
        else $error("queue occupancy beyond depth");
    a_idle_no_pend: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_IDLE |-> !pend_v_reg)
        else $error("result left pending in idle");
    a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        pop_en |-> occ_reg != '0)
        else $error("release from empty queue");
    a_insert_grows: assert property (@(posedge clk) disable iff (!rst_n)
        ins_en |=> occ_reg == $past(occ_reg) + OCC_W'(1))
        else $error("insert did not grow queue");
`endif

endmodule

@@ rtl/core/gre_rco_chk.sv @@
// Header, length and staleness checks plus PPP framing decisions for one packet.
module gre_rco_chk (
    input  logic [15:0]        total_length,
    input  logic [15:0]        gre_flags,
    input  logic [15:0]        gre_protocol,
    input  logic [15:0]        payload_length,
    input  logic [15:0]        call_id,
    input  logic [31:0]        sequence_req,
    input  logic [7:0]         byte0,
    input  logic [7:0]         byte1,
    input  logic [7:0]         byte2,
    input  logic [15:0]        local_call_id,
    input  logic [31:0]        expected_sequence,
    output gre_rco_pkg::chk_t  chk
);
    import gre_rco_pkg::*;

    logic [4:0]  hdr;
    logic        hdr_bad;
    logic [31:0] seq_diff;
    logic        stale;
    logic        strip;
    logic [16:0] len_a;
    logic [16:0] len_b;
    logic [7:0]  first;
    logic        prep;

    always_comb
    begin
        hdr = 5'd8 + (gre_flags[SEQ_BIT] ? 5'd4 : 5'd0) + (gre_flags[ACK_BIT] ? 5'd4 : 5'd0);
        hdr_bad = (gre_protocol != GRE_TYPE) || (call_id != local_call_id)
               || ((gre_flags & BITS_MASK) != BITS_WANT)
               || (total_length < {11'd0, hdr})
               || ((total_length - {11'd0, hdr}) != payload_length);
        seq_diff = sequence_req - expected_sequence;
        stale    = gre_flags[SEQ_BIT] && seq_diff[31];
        strip    = (payload_length >= 16'd2) && (byte0 == ADDR_BYTE) && (byte1 == CTRL_BYTE);
        len_a    = strip ? {1'b0, payload_length} - 17'd2 : {1'b0, payload_length};
        first    = strip ? byte2 : byte0;
        prep     = (len_a != 17'd0) && first[0];
        len_b    = prep ? len_a + 17'd1 : len_a;
        chk.drop  = hdr_bad || stale || (len_b < 17'd2);
        chk.seqd  = gre_flags[SEQ_BIT];
        chk.strip = strip;
        chk.prep  = prep;
    end

endmodule

@@ test/gre_rco_scoreboard.sv @@
// Scoreboard class: predicts GRE check/reorder results and compares output beats.
`timescale 1ns / 1ps
package gre_rco_sb_pkg;
    import gre_rco_pkg::*;

    typedef struct packed {
        logic        op;
        logic [7:0]  handle;
        logic [15:0] total_length;
        logic [15:0] gre_flags;
        logic [15:0] gre_protocol;
        logic [15:0] payload_length;
        logic [15:0] call_id;
        logic [31:0] sequence_req;
        logic [7:0]  byte0;
        logic [7:0]  byte1;
        logic [7:0]  byte2;
    } desc_t;

    typedef struct packed {
        kind_t      kind;
        logic [7:0] handle;
        logic       strip;
        logic       prep;
        logic       last;
    } beat_t;

    class gre_rco_scoreboard;
        logic [15:0] call_id_reg;
        logic [4:0]  thresh_reg;
        logic [9:0]  hz_reg;
        logic [31:0] q_seq [QDEPTH];
        logic [31:0] q_stamp [QDEPTH];
        logic [7:0]  q_handle [QDEPTH];
        logic        q_strip [QDEPTH];
        logic        q_prep [QDEPTH];
        int          occ;
        logic [31:0] next_seq;
        logic [31:0] ticks;
        logic        armed;
        logic [31:0] deadline;
        beat_t       pending[$];
        beat_t       step_out[$];

        function new();
            call_id_reg = 16'd0;
            thresh_reg = 5'd16;
            hz_reg = 10'd100;
            occ = 0;
            next_seq = 32'd0;
            ticks = 32'd0;
            armed = 1'b0;
            deadline = 32'd0;
        endfunction

        function void write_reg(logic [1:0] idx, logic [15:0] v);
            if (idx == REG_CALL_ID) call_id_reg = v;
            else if (idx == REG_THRESH) thresh_reg = v[4:0];
            else if (idx == REG_HZ) hz_reg = v[9:0];
        endfunction

        function void put(kind_t k, logic [7:0] h, logic s, logic p);
            beat_t b;
            b.kind = k;
            b.handle = h;
            b.strip = s;
            b.prep = p;
            b.last = 1'b0;
            step_out.push_back(b);
        endfunction

        function void pop_head();
            for (int i = 1; i < occ; i++) begin
                q_seq[i-1] = q_seq[i];
                q_stamp[i-1] = q_stamp[i];
                q_handle[i-1] = q_handle[i];
                q_strip[i-1] = q_strip[i];
                q_prep[i-1] = q_prep[i];
            end
            occ--;
        endfunction

        function void release_heads();
            int thr;
            logic [31:0] age;
            logic [31:0] d;
            thr = (thresh_reg > QDEPTH) ? QDEPTH : thresh_reg;
            age = (hz_reg > 5) ? hz_reg - 5 : 0;
            while (occ > 0) begin
                d = ticks - q_stamp[0];
                if (occ < thr && d < age && q_seq[0] != next_seq) break;
                next_seq = q_seq[0] + 1;
                put(KIND_DELIVER, q_handle[0], q_strip[0], q_prep[0]);
                pop_head();
            end
            if (occ > 0 && !armed) begin
                armed = 1'b1;
                deadline = ticks + hz_reg;
            end
        endfunction

        function void packet(desc_t d);
            logic [16:0] hdr;
            logic [16:0] len;
            logic [7:0]  first;
            logic        strip, prep, seqd;
            logic [31:0] diff, stamp;
            int          pos;
            seqd = d.gre_flags[SEQ_BIT];
            hdr = 17'(8 + (seqd ? 4 : 0) + (d.gre_flags[ACK_BIT] ? 4 : 0));
            if (d.total_length < 8 || d.gre_protocol != GRE_TYPE || d.call_id != call_id_reg
                || (d.gre_flags & BITS_MASK) != BITS_WANT || d.total_length < hdr
                || d.total_length - hdr != d.payload_length) begin
                put(KIND_DROP, d.handle, 0, 0);
                return;
            end
            diff = d.sequence_req - next_seq;
            if (seqd && diff[31]) begin
                put(KIND_DROP, d.handle, 0, 0);
                return;
            end
            len = {1'b0, d.payload_length};
            first = d.byte0;
            strip = 0;
            prep = 0;
            if (len >= 2 && d.byte0 == ADDR_BYTE && d.byte1 == CTRL_BYTE) begin
                strip = 1;
                len -= 2;
                first = d.byte2;
            end
            if (len >= 1 && first[0]) begin
                prep = 1;
                len += 1;
            end
            if (len < 2) begin
                put(KIND_DROP, d.handle, 0, 0);
                return;
            end
            if (seqd) begin
                armed = 0;
                pos = occ;
                stamp = ticks;
                for (int i = 0; i < occ; i++) begin
                    diff = d.sequence_req - q_seq[i];
                    if (diff == 0) begin
                        put(KIND_DROP, d.handle, 0, 0);
                        return;
                    end
                    if (diff[31]) begin
                        pos = i;
                        stamp = q_stamp[i];
                        break;
                    end
                end
                if (occ >= QDEPTH) begin
                    put(KIND_DROP, d.handle, 0, 0);
                    return;
                end
                for (int i = occ; i > pos; i--) begin
                    q_seq[i] = q_seq[i-1];
                    q_stamp[i] = q_stamp[i-1];
                    q_handle[i] = q_handle[i-1];
                    q_strip[i] = q_strip[i-1];
                    q_prep[i] = q_prep[i-1];
                end
                q_seq[pos] = d.sequence_req;
                q_stamp[pos] = stamp;
                q_handle[pos] = d.handle;
                q_strip[pos] = strip;
                q_prep[pos] = prep;
                occ++;
                release_heads();
                return;
            end
            for (int i = 0; i < occ; i++) put(KIND_PURGE, q_handle[i], 0, 0);
            occ = 0;
            put(KIND_DELIVER, d.handle, strip, prep);
        endfunction

        function void note_item(desc_t d);
            logic [31:0] dd;
            step_out.delete();
            if (d.op) begin
                ticks++;
                dd = ticks - deadline;
                if (armed && !dd[31]) begin
                    armed = 0;
                    release_heads();
                end
            end else begin
                packet(d);
            end
            if (step_out.size() > 0) step_out[$].last = 1;
            foreach (step_out[i]) pending.push_back(step_out[i]);
        endfunction

        function bit check_beat(beat_t got, output beat_t want);
            if (pending.size() == 0) return 0;
            want = pending.pop_front();
            return got == want;
        endfunction
    endclass
endpackage

@@ test/tb_gre_receive_check_and_reorder.sv @@
// Testbench top: drives descriptors and ticks, checks result beats against the scoreboard.
`timescale 1ns / 1ps
module tb_gre_receive_check_and_reorder;
    import gre_rco_pkg::*;
    import gre_rco_sb_pkg::*;

    localparam int WATCHDOG = 20000;

    logic        clk;
    logic        rst_n;
    logic        cfg_we;
    logic [1:0]  cfg_index;
    logic [15:0] cfg_data;
    gre_rco_item_if   item ();
    gre_rco_result_if result ();

    gre_receive_check_and_reorder u_dut (
        .clk(clk), .rst_n(rst_n), .item(item.sink), .result(result.source),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    gre_rco_scoreboard sb;
    int  errors;
    int  stall_cycles;
    bit  calm;
    logic [31:0] seq_base;
    logic [15:0] cid;

    initial
    begin
        clk = 0;
        forever #5 clk = ~clk;
    end

    task automatic report(string what);
        $display("mismatch: %s", what);
        errors++;
    endtask

    // result sink with random back-pressure
    initial
    begin
        beat_t got, want;
        int gap;
        result.ready = 0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (!calm && $urandom_range(0, 4) == 0) begin
                result.ready = 0;
                gap = $urandom_range(1, 3);
                repeat (gap) @(negedge clk);
            end
            result.ready = 1;
            @(posedge clk);
            if (result.valid) begin
                got.kind = kind_t'(result.kind);
                got.handle = result.out_handle;
                got.strip = result.strip_addr_ctrl;
                got.prep = result.prepend_zero;
                got.last = result.last;
                if (!sb.check_beat(got, want))
                    report($sformatf("got %p want %p (left %0d)", got, want,
                                     sb.pending.size()));
            end
        end
    end

    // watchdog on cycles without any beat
    initial
    begin
        stall_cycles = 0;
        forever
        begin
            @(posedge clk);
            if ((item.valid && item.ready) || (result.valid && result.ready))
                stall_cycles = 0;
            else
                stall_cycles++;
            if (stall_cycles >= WATCHDOG) begin
                $display("gre_receive_check_and_reorder verification failed");
                $finish;
            end
        end
    end

    task automatic write_reg(logic [1:0] idx, logic [15:0] v);
        @(negedge clk);
        cfg_we = 1;
        cfg_index = idx;
        cfg_data = v;
        @(negedge clk);
        cfg_we = 0;
        sb.write_reg(idx, v);
    endtask

    task automatic wait_idle();
        while (sb.pending.size() != 0) @(negedge clk);
        repeat (QDEPTH + 30) @(negedge clk);
    endtask

    task automatic send(desc_t d);
        int gap;
        @(negedge clk);
        if (!calm && $urandom_range(0, 3) == 0) begin
            item.valid = 0;
            gap = $urandom_range(1, 3);
            repeat (gap) @(negedge clk);
        end
        {item.op, item.handle, item.total_length, item.gre_flags, item.gre_protocol,
         item.payload_length, item.call_id, item.sequence_req, item.byte0, item.byte1,
         item.byte2} = d;
        item.valid = 1;
        @(posedge clk);
        while (!item.ready) @(posedge clk);
        sb.note_item(d);
        @(negedge clk);
        item.valid = 0;
    endtask

    function automatic desc_t good_pkt(bit seqd, bit ack, logic [31:0] sq, logic [15:0] plen);
        desc_t d;
        d.op = 1'b0;
        d.handle = 8'($urandom);
        d.gre_flags = 16'h2001 | (seqd ? 16'h1000 : 16'h0000) | (ack ? 16'h0080 : 16'h0000)
                      | ($urandom_range(0, 1) ? 16'h1080 & ~16'h1080 : 16'h0);
        if ($urandom_range(0, 3) == 0) d.gre_flags |= 16'h1080 ^ 16'hFFFF & ~BITS_MASK;
        d.gre_protocol = GRE_TYPE;
        d.payload_length = plen;
        d.total_length = plen + 16'd8 + (seqd ? 16'd4 : 16'd0) + (ack ? 16'd4 : 16'd0);
        d.call_id = cid;
        d.sequence_req = sq;
        d.byte0 = $urandom_range(0, 1) ? ADDR_BYTE : 8'($urandom);
        d.byte1 = $urandom_range(0, 1) ? CTRL_BYTE : 8'($urandom);
        d.byte2 = 8'($urandom);
        return d;
    endfunction

    function automatic desc_t tick_item();
        desc_t d;
        logic [159:0] raw;
        raw = {$urandom, $urandom, $urandom, $urandom, $urandom};
        d = raw[$bits(desc_t)-1:0];
        d.op = 1'b1;
        return d;
    endfunction

    task automatic send_tick_burst(int n);
        repeat (n) send(tick_item());
    endtask

    initial
    begin
        desc_t d;
        int r;
        logic [223:0] raw;
        rst_n = 0;
        cfg_we = 0;
        cfg_index = 0;
        cfg_data = 0;
        item.valid = 0;
        {item.op, item.handle, item.total_length, item.gre_flags, item.gre_protocol,
         item.payload_length, item.call_id, item.sequence_req, item.byte0, item.byte1,
         item.byte2} = '0;
        errors = 0;
        calm = 0;
        sb = new();
        cid = 0;
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n = 1;

        // directed: checks, strip/prepend, reorder, duplicate, stale, purge, timer
        write_reg(REG_CALL_ID, 16'hFFFF);
        cid = 16'hFFFF;
        write_reg(REG_THRESH, 16'd16);
        write_reg(REG_HZ, 16'd6);
        d = good_pkt(0, 0, 0, 16'd4); d.gre_protocol = 16'h0800; send(d);
        d = good_pkt(0, 0, 0, 16'd4); d.call_id = 16'd0; send(d);
        d = good_pkt(0, 0, 0, 16'd4); d.gre_flags = 16'hFFFF; send(d);
        d = good_pkt(0, 0, 0, 16'd4); d.total_length = 16'hFFFF; send(d);
        d = good_pkt(0, 0, 0, 16'd4); d.total_length = 16'd0; send(d);
        d = good_pkt(0, 1, 0, 16'd2); d.byte0 = ADDR_BYTE; d.byte1 = CTRL_BYTE; send(d);
        d = good_pkt(0, 0, 0, 16'd1); d.byte0 = 8'h21; send(d);
        d = good_pkt(0, 0, 0, 16'd1); d.byte0 = 8'h20; send(d);
        d = good_pkt(0, 0, 0, 16'hFFF7); send(d);
        send(good_pkt(1, 1, 3, 16'd5));
        send(good_pkt(1, 0, 1, 16'd5));
        send(good_pkt(1, 0, 1, 16'd5));
        send(good_pkt(1, 0, 0, 16'd5));
        send(good_pkt(1, 0, 32'hFFFF_FFFF, 16'd5));
        send(good_pkt(1, 0, 7, 16'd5));
        send_tick_burst(8);
        send(good_pkt(1, 0, 20, 16'd5));
        send(good_pkt(0, 0, 0, 16'd6));
        wait_idle();
        write_reg(REG_HZ, 16'd1000);
        write_reg(REG_THRESH, 16'd1);
        send(good_pkt(1, 0, 50, 16'd5));
        send(good_pkt(1, 0, 60, 16'd5));
        wait_idle();
        write_reg(REG_THRESH, 16'd0);
        send(good_pkt(1, 0, 70, 16'd5));
        wait_idle();

        // random phases with different settings
        for (int ph = 0; ph < 4; ph++)
        begin
            wait_idle();
            cid = (ph == 0) ? 16'h0000 : 16'($urandom);
            write_reg(REG_CALL_ID, cid);
            write_reg(REG_THRESH, 16'(ph == 0 ? 31 : (ph == 1 ? 16 : $urandom_range(2, 8))));
            write_reg(REG_HZ, 16'(ph == 2 ? 1023 : $urandom_range(6, 30)));
            if (ph == 3) calm = 1;
            seq_base = sb.next_seq;
            for (int k = 0; k < 30; k++)
            begin
                r = $urandom_range(0, 99);
                if (r < 55)
                    send(good_pkt(1, 1'($urandom_range(0, 1)),
                                  seq_base + $urandom_range(0, 12) - 2,
                                  16'($urandom_range(0, 3) == 0 ? $urandom
                                                                : $urandom_range(0, 8))));
                else if (r < 75) send_tick_burst($urandom_range(1, 12));
                else if (r < 82) send(good_pkt(0, 1'($urandom_range(0, 1)), $urandom,
                                               16'($urandom_range(0, 8))));
                else if (r < 92)
                begin
                    d = good_pkt(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)), $urandom,
                                 16'($urandom_range(0, 8)));
                    case ($urandom_range(0, 3))
                        0: d.gre_flags = 16'($urandom);
                        1: d.call_id = 16'($urandom);
                        2: d.total_length = 16'($urandom);
                        default: d.gre_protocol = 16'($urandom);
                    endcase
                    send(d);
                end else begin
                    raw = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
                    d = raw[$bits(desc_t)-1:0];
                    d.op = 1'b0;
                    send(d);
                end
                if (r % 8 == 0) seq_base = sb.next_seq;
                if (k == 15 && ph == 1) wait_idle();
            end
        end

        wait_idle();
        if (errors == 0 && sb.pending.size() == 0)
            $display("gre_receive_check_and_reorder verification clean");
        else
            $display("gre_receive_check_and_reorder verification failed");
        $finish;
    end
endmodule
